// ===== rtl/uete_pkg.sv =====
// Package for the USB endpoint transfer engine.
// Holds the command and token codes, the register indexes and the item and
// result types. It depends on nothing else.
package uete_pkg;

  // Command codes carried in the mode field.
  localparam logic [2:0] ModeStart      = 3'd0;
  localparam logic [2:0] ModeEvent      = 3'd1;
  localparam logic [2:0] ModeTakeback   = 3'd2;
  localparam logic [2:0] ModeStall      = 3'd3;
  localparam logic [2:0] ModeRequestZlp = 3'd4;
  localparam logic [2:0] ModeSetNotify  = 3'd5;

  // Token PIDs of a completion event.
  localparam logic [3:0] PidOut = 4'd1;
  localparam logic [3:0] PidIn  = 4'd9;

  // Sides of the endpoint.
  localparam logic SideRx = 1'b0;
  localparam logic SideTx = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CfgRxMaxPacket = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgTxMaxPacket = 2'd1;

  localparam logic [9:0] MaxPacketReset = 10'd64;

  typedef struct packed {
    logic [2:0]  mode;
    logic        direction;
    logic [31:0] buffer_address;
    logic [15:0] transfer_length;
    logic        toggle_given;
    logic        toggle_value;
    logic        notify_request;
    logic        descriptor_parity;
    logic [3:0]  token_pid;
    logic [9:0]  packet_count;
  } item_t;

  typedef struct packed {
    logic        arm_valid;
    logic        arm_direction;
    logic        arm_parity;
    logic [31:0] arm_address;
    logic [9:0]  arm_count;
    logic        arm_data01;
    logic        arm_stall;
    logic        accepted;
    logic        transfer_complete;
    logic        side_busy;
    logic [15:0] bytes_done;
  } result_t;

endpackage

// ===== rtl/usb_endpoint_transfer_engine.sv =====
// Transfer engine for one USB endpoint with an OUT (rx) and an IN (tx) side.
// Depends on uete_pkg for codes and the item and result types.
//
// Channel   Dir  Handshake               Payload
// item      in   item_valid/item_ready   mode .. packet_count
// result    out  result_valid/result_ready arm_valid .. bytes_done
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// An accepted item waits in the item register, then the whole update runs in
// one pass into the result register. One item is accepted every cycle while
// the result channel is not stalled; the item register and the result register
// form a two-stage pipeline. A stalled result holds the item register, and
// item_ready falls only when both stages are full. Reset (rst, synchronous)
// clears both sides, the pipeline valid flags and sets both max packet sizes
// to 64. Configuration writes are always taken.
module usb_endpoint_transfer_engine (
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  mode,
  input  logic        direction,
  input  logic [31:0] buffer_address,
  input  logic [15:0] transfer_length,
  input  logic        toggle_given,
  input  logic        toggle_value,
  input  logic        notify_request,
  input  logic        descriptor_parity,
  input  logic [3:0]  token_pid,
  input  logic [9:0]  packet_count,
  // Result channel.
  output logic        result_valid,
  input  logic        result_ready,
  output logic        arm_valid,
  output logic        arm_direction,
  output logic        arm_parity,
  output logic [31:0] arm_address,
  output logic [9:0]  arm_count,
  output logic        arm_data01,
  output logic        arm_stall,
  output logic        accepted,
  output logic        transfer_complete,
  output logic        side_busy,
  output logic [15:0] bytes_done,
  // Configuration channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [uete_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [9:0]                         cfg_data
);
  import uete_pkg::*;

  // Configuration registers.
  logic [9:0] rx_max_packet;
  logic [9:0] tx_max_packet;

  // Per-side state, index 0 is the rx side and index 1 the tx side.
  logic [31:0] next_address     [2];
  logic [15:0] bytes_to_go      [2];
  logic [15:0] done_count       [2];
  logic        zlp_pending      [2];
  logic        data_toggle      [2];
  logic        stall_pending    [2];
  logic        notify_pending   [2];
  logic        ping_pong_index  [2];
  logic [1:0]  descriptor_owned [2];

  logic [31:0] next_address_next     [2];
  logic [15:0] bytes_to_go_next      [2];
  logic [15:0] done_count_next       [2];
  logic        zlp_pending_next      [2];
  logic        data_toggle_next      [2];
  logic        stall_pending_next    [2];
  logic        notify_pending_next   [2];
  logic        ping_pong_index_next  [2];
  logic [1:0]  descriptor_owned_next [2];

  // Pipeline registers.
  item_t   item_q;
  logic    item_q_valid;
  result_t result_q;
  result_t result_next;

  logic    advance;

  // Arm request and its outcome.
  logic        arm_req;
  logic        arm_side;
  logic        arm_par;
  logic        arm_ok;
  logic [9:0]  arm_mp;
  logic [9:0]  arm_cnt;
  logic [15:0] event_sum;

  // The update runs when the item register is full and the result register
  // can take its outcome.
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      item_q <= '{mode: mode, direction: direction, buffer_address: buffer_address,
                  transfer_length: transfer_length, toggle_given: toggle_given,
                  toggle_value: toggle_value, notify_request: notify_request,
                  descriptor_parity: descriptor_parity, token_pid: token_pid,
                  packet_count: packet_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result_q <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_max_packet <= MaxPacketReset;
      tx_max_packet <= MaxPacketReset;
    end else if (cfg_valid) begin
      if (cfg_index == CfgRxMaxPacket) begin
        rx_max_packet <= cfg_data;
      end
      if (cfg_index == CfgTxMaxPacket) begin
        tx_max_packet <= cfg_data;
      end
    end
  end

  // One pass over the addressed side: the command updates the state, then an
  // arm attempt (if the command asks for one) works on the updated state.
  always_comb begin
    next_address_next     = next_address;
    bytes_to_go_next      = bytes_to_go;
    done_count_next       = done_count;
    zlp_pending_next      = zlp_pending;
    data_toggle_next      = data_toggle;
    stall_pending_next    = stall_pending;
    notify_pending_next   = notify_pending;
    ping_pong_index_next  = ping_pong_index;
    descriptor_owned_next = descriptor_owned;
    result_next           = '0;
    arm_req               = 1'b0;
    arm_side              = item_q.direction;
    event_sum             = 16'd0;

    unique case (item_q.mode)
      ModeStart: begin
        if (item_q.toggle_given) begin
          data_toggle_next[item_q.direction] = item_q.toggle_value;
        end
        next_address_next[item_q.direction] = item_q.buffer_address;
        bytes_to_go_next[item_q.direction]  = item_q.transfer_length;
        done_count_next[item_q.direction]   = 16'd0;
        if (item_q.notify_request) begin
          notify_pending_next[item_q.direction] = 1'b1;
        end
        arm_req = 1'b1;
      end
      ModeEvent: begin
        // The finished descriptor is released on the addressed side, while
        // the transfer bookkeeping follows the side named by the token.
        descriptor_owned_next[item_q.direction][item_q.descriptor_parity] = 1'b0;
        ping_pong_index_next[item_q.direction] = !ping_pong_index[item_q.direction];
        data_toggle_next[item_q.direction]     = !data_toggle[item_q.direction];
        if (item_q.token_pid == PidOut) begin
          result_next.accepted = 1'b1;
          arm_side  = SideRx;
          event_sum = done_count[SideRx] + {6'd0, item_q.packet_count};
          done_count_next[SideRx] = event_sum;
          // A zero-length, oversized or short packet ends an OUT transfer.
          if (item_q.packet_count == 10'd0 ||
              {6'd0, item_q.packet_count} > bytes_to_go[SideRx] ||
              item_q.packet_count < rx_max_packet) begin
            bytes_to_go_next[SideRx] = 16'd0;
          end else begin
            bytes_to_go_next[SideRx] = bytes_to_go[SideRx] - {6'd0, item_q.packet_count};
          end
          if (bytes_to_go_next[SideRx] != 16'd0) begin
            next_address_next[SideRx] = next_address[SideRx] +
                                        {22'd0, item_q.packet_count};
            arm_req = 1'b1;
          end else if (notify_pending[SideRx]) begin
            notify_pending_next[SideRx]   = 1'b0;
            result_next.transfer_complete = 1'b1;
          end
        end else if (item_q.token_pid == PidIn) begin
          result_next.accepted = 1'b1;
          arm_side  = SideTx;
          event_sum = done_count[SideTx] + {6'd0, item_q.packet_count};
          done_count_next[SideTx] = event_sum;
          if ({6'd0, item_q.packet_count} > bytes_to_go[SideTx]) begin
            bytes_to_go_next[SideTx] = 16'd0;
          end else begin
            bytes_to_go_next[SideTx] = bytes_to_go[SideTx] - {6'd0, item_q.packet_count};
          end
          if (bytes_to_go_next[SideTx] != 16'd0) begin
            next_address_next[SideTx] = next_address[SideTx] +
                                        {22'd0, item_q.packet_count};
            arm_req = 1'b1;
          end else if (zlp_pending[SideTx]) begin
            // The zero-length packet request is used up even if arming fails.
            zlp_pending_next[SideTx] = 1'b0;
            arm_req = 1'b1;
          end else if (notify_pending[SideTx]) begin
            notify_pending_next[SideTx]   = 1'b0;
            result_next.transfer_complete = 1'b1;
          end
        end
      end
      ModeTakeback: begin
        // Each released descriptor advances the ping-pong index once.
        ping_pong_index_next[item_q.direction] = ping_pong_index[item_q.direction] ^
          descriptor_owned[item_q.direction][0] ^ descriptor_owned[item_q.direction][1];
        descriptor_owned_next[item_q.direction] = 2'b00;
        next_address_next[item_q.direction]     = 32'd0;
        bytes_to_go_next[item_q.direction]      = 16'd0;
        done_count_next[item_q.direction]       = 16'd0;
        zlp_pending_next[item_q.direction]      = 1'b0;
        data_toggle_next[item_q.direction]      = 1'b0;
        stall_pending_next[item_q.direction]    = 1'b0;
        notify_pending_next[item_q.direction]   = 1'b0;
      end
      ModeStall: begin
        stall_pending_next[item_q.direction] = 1'b1;
      end
      ModeRequestZlp: begin
        zlp_pending_next[SideTx] = 1'b1;
      end
      ModeSetNotify: begin
        if (item_q.notify_request) begin
          notify_pending_next[item_q.direction] = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Arm the free descriptor: the one the ping-pong index points at, else
    // the other one. No buffer or no free descriptor means no arm.
    arm_par = ping_pong_index_next[arm_side];
    if (descriptor_owned_next[arm_side][arm_par]) begin
      arm_par = !arm_par;
    end
    arm_ok = arm_req && (next_address_next[arm_side] != 32'd0) &&
             !descriptor_owned_next[arm_side][arm_par];
    arm_mp  = (arm_side == SideTx) ? tx_max_packet : rx_max_packet;
    arm_cnt = (bytes_to_go_next[arm_side] < {6'd0, arm_mp}) ?
              bytes_to_go_next[arm_side][9:0] : arm_mp;
    if (arm_ok) begin
      result_next.arm_valid     = 1'b1;
      result_next.arm_direction = arm_side;
      result_next.arm_parity    = arm_par;
      result_next.arm_address   = next_address_next[arm_side];
      result_next.arm_count     = arm_cnt;
      result_next.arm_data01    = data_toggle_next[arm_side];
      result_next.arm_stall     = stall_pending_next[arm_side];
      stall_pending_next[arm_side] = 1'b0;
      descriptor_owned_next[arm_side][arm_par] = 1'b1;
    end
    if (item_q.mode == ModeStart) begin
      result_next.accepted = arm_ok;
    end

    result_next.side_busy  = (descriptor_owned_next[item_q.direction] != 2'b00) ||
                             (bytes_to_go_next[item_q.direction] != 16'd0) ||
                             zlp_pending_next[item_q.direction];
    result_next.bytes_done = done_count_next[item_q.direction];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        next_address[s]     <= 32'd0;
        bytes_to_go[s]      <= 16'd0;
        done_count[s]       <= 16'd0;
        zlp_pending[s]      <= 1'b0;
        data_toggle[s]      <= 1'b0;
        stall_pending[s]    <= 1'b0;
        notify_pending[s]   <= 1'b0;
        ping_pong_index[s]  <= 1'b0;
        descriptor_owned[s] <= 2'b00;
      end
    end else if (advance) begin
      next_address     <= next_address_next;
      bytes_to_go      <= bytes_to_go_next;
      done_count       <= done_count_next;
      zlp_pending      <= zlp_pending_next;
      data_toggle      <= data_toggle_next;
      stall_pending    <= stall_pending_next;
      notify_pending   <= notify_pending_next;
      ping_pong_index  <= ping_pong_index_next;
      descriptor_owned <= descriptor_owned_next;
    end
  end

  assign arm_valid         = result_q.arm_valid;
  assign arm_direction     = result_q.arm_direction;
  assign arm_parity        = result_q.arm_parity;
  assign arm_address       = result_q.arm_address;
  assign arm_count         = result_q.arm_count;
  assign arm_data01        = result_q.arm_data01;
  assign arm_stall         = result_q.arm_stall;
  assign accepted          = result_q.accepted;
  assign transfer_complete = result_q.transfer_complete;
  assign side_busy         = result_q.side_busy;
  assign bytes_done        = result_q.bytes_done;

  // An armed descriptor is owned afterwards.
  a_arm_owns: assert property (@(posedge clk) disable iff (rst)
    advance && arm_ok |=> descriptor_owned[$past(arm_side)][$past(arm_par)])
    else $error("armed descriptor not marked owned");

  // A takeback leaves the side with no owned descriptor and no bytes left.
  a_takeback_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item_q.mode == ModeTakeback |=>
      descriptor_owned[$past(item_q.direction)] == 2'b00 &&
      bytes_to_go[$past(item_q.direction)] == 16'd0)
    else $error("takeback left side state behind");

  // Without an arm, the descriptor fields of the result are all zero.
  a_no_arm_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !arm_valid |->
      arm_address == 32'd0 && arm_count == 10'd0 && !arm_stall && !arm_data01)
    else $error("descriptor fields set without an arm");

  // While the pipeline is stalled the endpoint state does not move.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(done_count[0]) && $stable(done_count[1]) &&
                 $stable(descriptor_owned[0]) && $stable(descriptor_owned[1]))
    else $error("endpoint state changed without an update");

endmodule
